@@ sv/tqua_pkg.sv @@
// ----------------------------------------------------------------------------
// tqua_pkg: shared types and constants for the two-qubit unitary accumulator
// Gate kinds, mode codes, sequencer states and the per-gate term selection
// used by the shared complex multiply-add unit.
// ----------------------------------------------------------------------------
package tqua_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 18;
	localparam int DIM           = 4;
	localparam int ENTRIES       = DIM * DIM;
	localparam int IDX_W         = $clog2(DIM);
	localparam int ADDR_W        = $clog2(ENTRIES);
	localparam int STEP_W        = $clog2(ENTRIES);

	localparam logic signed [ELEM_W-1:0] ELEM_MAX = 18'sd131071;
	localparam logic signed [ELEM_W-1:0] ELEM_MIN = -18'sd131072;

	// mode codes
	localparam logic [3:0] MODE_IDENT = 4'd0;
	localparam logic [3:0] MODE_CNOT  = 4'd1;
	localparam logic [3:0] MODE_X     = 4'd2;
	localparam logic [3:0] MODE_Y     = 4'd3;
	localparam logic [3:0] MODE_Z     = 4'd4;
	localparam logic [3:0] MODE_RX    = 4'd5;
	localparam logic [3:0] MODE_RY    = 4'd6;
	localparam logic [3:0] MODE_RZ    = 4'd7;

	typedef enum logic [2:0] {
		G_COPY,
		G_CNOT,
		G_X,
		G_Y,
		G_Z,
		G_RX,
		G_RY,
		G_RZ
	} gate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_FETCH,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		K_ZERO,
		K_ONE,
		K_C,
		K_S
	} coef_t;

	typedef enum logic [1:0] {
		OP_AR,
		OP_AI,
		OP_BR,
		OP_BI
	} opnd_t;

	typedef struct packed {
		coef_t coef;
		opnd_t opnd;
		logic  neg;
	} term_t;

	// [0],[1]: real part terms; [2],[3]: imaginary part terms
	typedef term_t [3:0] term_set_t;

	function automatic term_t mk_term(coef_t k, opnd_t op, logic neg);
		term_t t;
		t.coef = k;
		t.opnd = op;
		t.neg  = neg;
		return t;
	endfunction

	// Row of a pair. lay=0: pair rows differ in index bit 1, else in bit 0.
	function automatic logic [IDX_W-1:0] pair_row(logic lay, logic j, logic side_b);
		return lay ? {j, side_b} : {side_b, j};
	endfunction

	// Terms for the new |0> side (side_b=0) or |1> side (side_b=1) element.
	function automatic term_set_t gate_terms(gate_t g, logic side_b);
		term_set_t t;
		t = '0;
		case (g)
			G_X: begin
				t[0] = mk_term(K_ONE, side_b ? OP_AR : OP_BR, 1'b0);
				t[2] = mk_term(K_ONE, side_b ? OP_AI : OP_BI, 1'b0);
			end
			G_Y: begin
				if (side_b) begin
					t[0] = mk_term(K_ONE, OP_AI, 1'b1);
					t[2] = mk_term(K_ONE, OP_AR, 1'b0);
				end else begin
					t[0] = mk_term(K_ONE, OP_BI, 1'b0);
					t[2] = mk_term(K_ONE, OP_BR, 1'b1);
				end
			end
			G_Z: begin
				t[0] = mk_term(K_ONE, side_b ? OP_BR : OP_AR, side_b);
				t[2] = mk_term(K_ONE, side_b ? OP_BI : OP_AI, side_b);
			end
			G_RX: begin
				if (side_b) begin
					t[0] = mk_term(K_S, OP_AI, 1'b0);
					t[1] = mk_term(K_C, OP_BR, 1'b0);
					t[2] = mk_term(K_S, OP_AR, 1'b1);
					t[3] = mk_term(K_C, OP_BI, 1'b0);
				end else begin
					t[0] = mk_term(K_C, OP_AR, 1'b0);
					t[1] = mk_term(K_S, OP_BI, 1'b0);
					t[2] = mk_term(K_C, OP_AI, 1'b0);
					t[3] = mk_term(K_S, OP_BR, 1'b1);
				end
			end
			G_RY: begin
				if (side_b) begin
					t[0] = mk_term(K_S, OP_AR, 1'b0);
					t[1] = mk_term(K_C, OP_BR, 1'b0);
					t[2] = mk_term(K_S, OP_AI, 1'b0);
					t[3] = mk_term(K_C, OP_BI, 1'b0);
				end else begin
					t[0] = mk_term(K_C, OP_AR, 1'b0);
					t[1] = mk_term(K_S, OP_BR, 1'b1);
					t[2] = mk_term(K_C, OP_AI, 1'b0);
					t[3] = mk_term(K_S, OP_BI, 1'b1);
				end
			end
			G_RZ: begin
				if (side_b) begin
					t[0] = mk_term(K_C, OP_BR, 1'b0);
					t[1] = mk_term(K_S, OP_BI, 1'b1);
					t[2] = mk_term(K_C, OP_BI, 1'b0);
					t[3] = mk_term(K_S, OP_BR, 1'b0);
				end else begin
					t[0] = mk_term(K_C, OP_AR, 1'b0);
					t[1] = mk_term(K_S, OP_AI, 1'b0);
					t[2] = mk_term(K_C, OP_AI, 1'b0);
					t[3] = mk_term(K_S, OP_AR, 1'b1);
				end
			end
			default: begin
				// plain copy of the element (also the untouched pair of a CNOT)
				t[0] = mk_term(K_ONE, side_b ? OP_BR : OP_AR, 1'b0);
				t[2] = mk_term(K_ONE, side_b ? OP_BI : OP_AI, 1'b0);
			end
		endcase
		return t;
	endfunction

endpackage

@@ sv/two_qubit_unitary_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// two_qubit_unitary_accumulator_top: 4x4 complex unitary accumulator
// Applies one single-qubit gate or CNOT per command to a stored 4x4 complex
// matrix, or reloads the identity, and returns one element of the matrix.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer when            Payload
// -------   ---------  -----------------------  ---------------------------------
// command   in         start && !busy           mode, qubit, half_cos, half_sin,
//                                               row, col
// result    out        done (one cycle)         elem_real, elem_imag
//
// Sequence: a gate command (modes 1 to 7) runs one pass of the shared complex
// multiply-add unit per matrix element, then the drain, fetch and result
// states; reload and read-only commands go straight to fetch and result.
// The single write port of the matrix store allows one element per pass.
// Reset: arst_n clears the sequencer and the per-entry valid bits, so the
// matrix reads as the identity straight away. Stalls: none, done is never held.
//
module two_qubit_unitary_accumulator_top #(
	parameter int FRAC_BITS = tqua_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [3:0]                            mode,
	input  logic                                  qubit,
	input  logic signed [tqua_pkg::ELEM_W-1:0]    half_cos,
	input  logic signed [tqua_pkg::ELEM_W-1:0]    half_sin,
	input  logic [tqua_pkg::IDX_W-1:0]            row,
	input  logic [tqua_pkg::IDX_W-1:0]            col,
	output logic                                  done,
	output logic signed [tqua_pkg::ELEM_W-1:0]    elem_real,
	output logic signed [tqua_pkg::ELEM_W-1:0]    elem_imag
);

	localparam int EW = tqua_pkg::ELEM_W;
	localparam int AW = tqua_pkg::ADDR_W;
	localparam int NE = tqua_pkg::ENTRIES;
	localparam int SW_ = tqua_pkg::STEP_W;
	// coefficient width: +/-2^FRAC_BITS or an 18-bit operand
	localparam int CW = (FRAC_BITS + 2 > EW) ? FRAC_BITS + 2 : EW;
	localparam int PW = CW + EW;
	localparam int SW = PW + 2;

	localparam int unsigned ONE_INT = 1 << FRAC_BITS;
	localparam logic signed [CW-1:0] ONE_C = CW'(ONE_INT);
	// identity diagonal saturates when one does not fit
	localparam logic signed [EW-1:0] ONE_SAT =
		(FRAC_BITS < EW - 1) ? EW'(ONE_INT) : tqua_pkg::ELEM_MAX;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(tqua_pkg::ELEM_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(tqua_pkg::ELEM_MIN);

	// ---------------------------------------------------------------- control
	tqua_pkg::state_t state_q, state_d;
	logic [SW_-1:0]   cnt_q;
	logic             accept;
	logic             issue;     // read of a row pair this cycle
	logic             fetch;     // read of the requested element
	logic             clear_id;  // identity reload
	logic             run_req;

	// command registers
	tqua_pkg::gate_t           gate_q, gate_d;
	logic                      lay_q;
	logic signed [EW-1:0]      c_q, s_q;
	logic [tqua_pkg::IDX_W-1:0] row_q, col_q;

	// pipeline
	logic                   v_s1, v_s2;
	logic [SW_-1:0]         n_s1, n_s2;
	logic signed [PW-1:0]   prod_s2 [4];
	logic [3:0]             neg_s2;

	// matrix store
	logic signed [EW-1:0]   re_mem_q [NE];
	logic signed [EW-1:0]   im_mem_q [NE];
	logic [NE-1:0]          valid_q;
	logic signed [EW-1:0]   rd_ar_q, rd_ai_q, rd_br_q, rd_bi_q;
	logic [AW-1:0]          rd_addr_a, rd_addr_b, wr_addr;
	logic signed [EW-1:0]   wr_re, wr_im;

	// command decode
	always_comb begin
		run_req = mode inside {[tqua_pkg::MODE_CNOT:tqua_pkg::MODE_RZ]};
		case (mode)
			tqua_pkg::MODE_CNOT: gate_d = tqua_pkg::G_CNOT;
			tqua_pkg::MODE_X:    gate_d = tqua_pkg::G_X;
			tqua_pkg::MODE_Y:    gate_d = tqua_pkg::G_Y;
			tqua_pkg::MODE_Z:    gate_d = tqua_pkg::G_Z;
			tqua_pkg::MODE_RX:   gate_d = tqua_pkg::G_RX;
			tqua_pkg::MODE_RY:   gate_d = tqua_pkg::G_RY;
			tqua_pkg::MODE_RZ:   gate_d = tqua_pkg::G_RZ;
			default:             gate_d = tqua_pkg::G_COPY;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tqua_pkg::S_IDLE: begin
				if (start) begin
					state_d = run_req ? tqua_pkg::S_RUN : tqua_pkg::S_FETCH;
				end
			end
			tqua_pkg::S_RUN: begin
				if (cnt_q == SW_'(NE - 1)) begin
					state_d = tqua_pkg::S_DRAIN;
				end
			end
			tqua_pkg::S_DRAIN: begin
				// last write lands at the end of the cycle where v_s1 has gone
				if (!v_s1) begin
					state_d = tqua_pkg::S_FETCH;
				end
			end
			tqua_pkg::S_FETCH: state_d = tqua_pkg::S_RESP;
			tqua_pkg::S_RESP:  state_d = tqua_pkg::S_IDLE;
			default:           state_d = tqua_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy     = (state_q != tqua_pkg::S_IDLE);
		done     = (state_q == tqua_pkg::S_RESP);
		accept   = start && (state_q == tqua_pkg::S_IDLE);
		issue    = (state_q == tqua_pkg::S_RUN) && !cnt_q[0];
		fetch    = (state_q == tqua_pkg::S_FETCH);
		clear_id = accept && (mode == tqua_pkg::MODE_IDENT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqua_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tqua_pkg::S_RUN) begin
				cnt_q <= cnt_q + SW_'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gate_q <= gate_d;
			// CNOT swaps within the pair layout of the other qubit
			lay_q  <= (mode == tqua_pkg::MODE_CNOT) ? ~qubit : qubit;
			c_q    <= half_cos;
			s_q    <= half_sin;
			row_q  <= row;
			col_q  <= col;
		end
	end

	// ------------------------------------------------------------ read stage
	// step = {pair, column, side}; even counts read both rows of a pair
	assign rd_addr_a = fetch ? {row_q, col_q}
		: {tqua_pkg::pair_row(lay_q, cnt_q[SW_-1], 1'b0), cnt_q[SW_-2:1]};
	assign rd_addr_b = {tqua_pkg::pair_row(lay_q, cnt_q[SW_-1], 1'b1), cnt_q[SW_-2:1]};

	always_ff @(posedge clk) begin
		if (issue || fetch) begin
			rd_ar_q <= valid_q[rd_addr_a] ? re_mem_q[rd_addr_a]
				: ((rd_addr_a[AW-1:AW/2] == rd_addr_a[AW/2-1:0]) ? ONE_SAT : '0);
			rd_ai_q <= valid_q[rd_addr_a] ? im_mem_q[rd_addr_a] : '0;
			rd_br_q <= valid_q[rd_addr_b] ? re_mem_q[rd_addr_b]
				: ((rd_addr_b[AW-1:AW/2] == rd_addr_b[AW/2-1:0]) ? ONE_SAT : '0);
			rd_bi_q <= valid_q[rd_addr_b] ? im_mem_q[rd_addr_b] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == tqua_pkg::S_RUN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s1 <= cnt_q;
		n_s2 <= n_s1;
	end

	// ------------------------------------------------------- multiply stage
	// Shared complex multiply-add: four products per new element, selected
	// per gate; rd registers hold one row pair for both sides of it.
	tqua_pkg::gate_t      g_eff;
	tqua_pkg::term_set_t  terms;
	logic signed [CW-1:0] coef_v [4];
	logic signed [EW-1:0] opnd_v [4];

	always_comb begin
		if (gate_q == tqua_pkg::G_CNOT) begin
			g_eff = n_s1[SW_-1] ? tqua_pkg::G_X : tqua_pkg::G_COPY;
		end else begin
			g_eff = gate_q;
		end
		terms = tqua_pkg::gate_terms(g_eff, n_s1[0]);
		for (int k = 0; k < 4; k++) begin
			case (terms[k].coef)
				tqua_pkg::K_ONE: coef_v[k] = ONE_C;
				tqua_pkg::K_C:   coef_v[k] = CW'(c_q);
				tqua_pkg::K_S:   coef_v[k] = CW'(s_q);
				default:         coef_v[k] = '0;
			endcase
			case (terms[k].opnd)
				tqua_pkg::OP_AI: opnd_v[k] = rd_ai_q;
				tqua_pkg::OP_BR: opnd_v[k] = rd_br_q;
				tqua_pkg::OP_BI: opnd_v[k] = rd_bi_q;
				default:         opnd_v[k] = rd_ar_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= coef_v[k] * opnd_v[k];
			neg_s2[k]  <= terms[k].neg;
		end
	end

	// ------------------------------------------------- sum, round, write
	function automatic logic signed [EW-1:0] rnd_sat(logic signed [SW-1:0] v);
		logic signed [SW-1:0] q;
		q = (v + HALF) >>> FRAC_BITS;
		if (q > SAT_HI) begin
			return tqua_pkg::ELEM_MAX;
		end else if (q < SAT_LO) begin
			return tqua_pkg::ELEM_MIN;
		end
		return q[EW-1:0];
	endfunction

	logic signed [SW-1:0] term_v [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			term_v[k] = neg_s2[k] ? -SW'(prod_s2[k]) : SW'(prod_s2[k]);
		end
		wr_re   = rnd_sat(term_v[0] + term_v[1]);
		wr_im   = rnd_sat(term_v[2] + term_v[3]);
		wr_addr = {tqua_pkg::pair_row(lay_q, n_s2[SW_-1], n_s2[0]), n_s2[SW_-2:1]};
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			re_mem_q[wr_addr] <= wr_re;
			im_mem_q[wr_addr] <= wr_im;
		end
	end

	// entry not yet written since reset or reload reads as identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear_id) begin
			valid_q <= '0;
		end else if (v_s2) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign elem_real = rd_ar_q;
	assign elem_imag = rd_ai_q;

	// ------------------------------------------------------------- checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command transfer did not raise busy");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after result transfer");

	a_fetch_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tqua_pkg::S_FETCH) |-> (!v_s1 && !v_s2))
		else $error("element fetched before last write");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && v_s2) |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
		else $error("pair read overlaps a pending write");

endmodule
